### design/irpdfe_pkg.sv
// ----------------------------------------------------------------------------
// irpdfe_pkg
// Shared types, constants and the frame bit function for the pulse-distance
// infrared frame encoder.
// ----------------------------------------------------------------------------
package irpdfe_pkg;

   localparam int unsigned BitsPerFrameDefault = 32;

   localparam int unsigned MarkWidth   = 14;
   localparam int unsigned UnitWidth   = 12;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [MarkWidth-1:0] LeaderMarkReset  = 14'd9000;
   localparam logic [MarkWidth-1:0] LeaderSpaceReset = 14'd4500;
   localparam logic [UnitWidth-1:0] UnitReset        = 12'd562;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_LEADER_MARK  = 2'd0,
      REG_LEADER_SPACE = 2'd1,
      REG_UNIT         = 2'd2,
      REG_NONE         = 2'd3
   } reg_index_type;

   // what one cell of the chain holds
   typedef enum logic [1:0] {
      SEG_LEADER = 2'd0,
      SEG_ZERO   = 2'd1,
      SEG_ONE    = 2'd2,
      SEG_STOP   = 2'd3
   } seg_kind_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic [MarkWidth-1:0] leader_mark;
      logic [MarkWidth-1:0] leader_space;
      logic [UnitWidth-1:0] unit;
   } timing_cfg_type;

   // bit idx of the sequence addr, ~addr, cmd, ~cmd; error mode sends the
   // complemented bytes lsb first
   function automatic logic frame_bit(
      input logic [ByteWidth-1:0] addr,
      input logic [ByteWidth-1:0] cmd,
      input logic                 err,
      input logic [4:0]           idx
   );
      logic [1:0] group;
      logic [2:0] pos;
      logic [2:0] msb_pos;
      logic [2:0] inv_pos;
      logic       bit_val;
      group   = idx[4:3];
      pos     = idx[2:0];
      msb_pos = 3'd7 - pos;
      inv_pos = err ? pos : msb_pos;
      case (group)
         2'd0:    bit_val = addr[msb_pos];
         2'd1:    bit_val = ~addr[inv_pos];
         2'd2:    bit_val = cmd[msb_pos];
         default: bit_val = ~cmd[inv_pos];
      endcase
      return bit_val;
   endfunction

endpackage

### design/irpdfe_cell.sv
// ----------------------------------------------------------------------------
// irpdfe_cell
// One cell of the segment chain: loads its segment kind with a new frame and
// otherwise takes the kind of its neighbor on each shift.
// ----------------------------------------------------------------------------
module irpdfe_cell (
   input  logic                      clock,
   input  irpdfe_pkg::cell_ctrl_type ctrl,
   input  irpdfe_pkg::seg_kind_type  load_kind,
   input  irpdfe_pkg::seg_kind_type  next_kind,
   output irpdfe_pkg::seg_kind_type  kind
);

   irpdfe_pkg::seg_kind_type kind_ff;
   irpdfe_pkg::seg_kind_type kind_in;

   always_comb begin
      if (ctrl.load) begin
         kind_in = load_kind;
      end else if (ctrl.shift) begin
         kind_in = next_kind;
      end else begin
         kind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

### design/irpdfe_seg_out.sv
// ----------------------------------------------------------------------------
// irpdfe_seg_out
// Output register: turns the head cell's segment kind into mark and space
// durations and holds the result while the receiver stalls.
// ----------------------------------------------------------------------------
module irpdfe_seg_out (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    head_valid,
   input  irpdfe_pkg::seg_kind_type                head_kind,
   input  irpdfe_pkg::timing_cfg_type              cfg,
   output logic                                    out_valid,
   output logic [irpdfe_pkg::MarkWidth-1:0]        out_mark,
   output logic [irpdfe_pkg::MarkWidth-1:0]        out_space,
   output logic                                    out_last
);

   logic                               valid_ff;
   logic [irpdfe_pkg::MarkWidth-1:0]   mark_ff;
   logic [irpdfe_pkg::MarkWidth-1:0]   mark_in;
   logic [irpdfe_pkg::MarkWidth-1:0]   space_ff;
   logic [irpdfe_pkg::MarkWidth-1:0]   space_in;
   logic                               last_ff;
   logic                               last_in;
   logic [irpdfe_pkg::MarkWidth-1:0]   unit_w;
   logic [irpdfe_pkg::MarkWidth-1:0]   unit3_w;

   assign unit_w  = {{(irpdfe_pkg::MarkWidth-irpdfe_pkg::UnitWidth){1'b0}}, cfg.unit};
   // three units never exceeds 12285, fits in 14 bits
   assign unit3_w = (unit_w << 1) + unit_w;

   always_comb begin
      mark_in  = unit_w;
      space_in = unit_w;
      last_in  = 1'b0;
      case (head_kind)
         irpdfe_pkg::SEG_LEADER: begin
            mark_in  = cfg.leader_mark;
            space_in = cfg.leader_space;
         end
         irpdfe_pkg::SEG_ZERO: begin
            space_in = unit_w;
         end
         irpdfe_pkg::SEG_ONE: begin
            space_in = unit3_w;
         end
         default: begin
            space_in = '0;
            last_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mark_ff  <= mark_in;
         space_ff <= space_in;
         last_ff  <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mark  = mark_ff;
   assign out_space = space_ff;
   assign out_last  = last_ff;

endmodule

### design/ir_pulse_distance_frame_encoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder
// Turns an address/command request into the pulse-distance frame: leader,
// one segment per data bit and a stop mark, one segment per cycle unless rsp_stall holds it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | address, command_byte, error_frame
//  rsp     | out       | rsp_valid/rsp_stall  | mark_us, space_us, last
//  csr     | in/out    | apb, pready always 1 | leader_mark_us, leader_space_us, unit_us
//
//  a request loads a chain of BITS_PER_FRAME+2 cells; the chain shifts one
//  segment into the output register per cycle unless stalled, and the next
//  request loads as the stop segment leaves, with no gap between frames.
//  the chain holds while a segment waits in the output register under rsp_stall.
//  reset empties the chain and restores the timing registers.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_encoder #(
   parameter int unsigned BITS_PER_FRAME = irpdfe_pkg::BitsPerFrameDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [irpdfe_pkg::ByteWidth-1:0]        req_address,
   input  logic [irpdfe_pkg::ByteWidth-1:0]        req_command_byte,
   input  logic                                    req_error_frame,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [irpdfe_pkg::MarkWidth-1:0]        rsp_mark_us,
   output logic [irpdfe_pkg::MarkWidth-1:0]        rsp_space_us,
   output logic                                    rsp_last,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [irpdfe_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [irpdfe_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [irpdfe_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   localparam int unsigned NumCells = BITS_PER_FRAME + 2;
   localparam int unsigned CntWidth = $clog2(NumCells + 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(NumCells);
   localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

   // ---------------- configuration registers ----------------
   irpdfe_pkg::timing_cfg_type cfg_ff;
   irpdfe_pkg::timing_cfg_type cfg_in;
   irpdfe_pkg::reg_index_type  csr_index;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = irpdfe_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            irpdfe_pkg::REG_LEADER_MARK:
               cfg_in.leader_mark  = csr_pwdata[irpdfe_pkg::MarkWidth-1:0];
            irpdfe_pkg::REG_LEADER_SPACE:
               cfg_in.leader_space = csr_pwdata[irpdfe_pkg::MarkWidth-1:0];
            irpdfe_pkg::REG_UNIT:
               cfg_in.unit         = csr_pwdata[irpdfe_pkg::UnitWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark  <= irpdfe_pkg::LeaderMarkReset;
         cfg_ff.leader_space <= irpdfe_pkg::LeaderSpaceReset;
         cfg_ff.unit         <= irpdfe_pkg::UnitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         irpdfe_pkg::REG_LEADER_MARK:
            csr_prdata[irpdfe_pkg::MarkWidth-1:0] = cfg_ff.leader_mark;
         irpdfe_pkg::REG_LEADER_SPACE:
            csr_prdata[irpdfe_pkg::MarkWidth-1:0] = cfg_ff.leader_space;
         irpdfe_pkg::REG_UNIT:
            csr_prdata[irpdfe_pkg::UnitWidth-1:0] = cfg_ff.unit;
         default: ;
      endcase
   end

   // ---------------- chain control ----------------
   logic                      out_valid;
   logic                      advance;
   logic                      req_accept;
   logic [CntWidth-1:0]       cnt_ff;
   logic [CntWidth-1:0]       cnt_in;
   irpdfe_pkg::cell_ctrl_type ctrl;

   assign advance    = !out_valid || !rsp_stall;
   // load when empty, or when the last segment moves out this cycle
   assign req_stall  = !((cnt_ff == '0) || ((cnt_ff == CntOne) && advance));
   assign req_accept = req_valid && !req_stall;

   assign ctrl.load  = req_accept;
   assign ctrl.shift = advance;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         cnt_in = CntFull;
      end else if (advance && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - CntOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // ---------------- cell chain ----------------
   irpdfe_pkg::seg_kind_type kinds     [NumCells];
   irpdfe_pkg::seg_kind_type load_kinds[NumCells];

   for (genvar j = 0; j < NumCells; j++) begin : g_cell
      irpdfe_pkg::seg_kind_type next_kind;

      if (j == 0) begin : g_head
         assign load_kinds[j] = irpdfe_pkg::SEG_LEADER;
      end else if (j == NumCells - 1) begin : g_tail
         assign load_kinds[j] = irpdfe_pkg::SEG_STOP;
      end else begin : g_data
         assign load_kinds[j] = irpdfe_pkg::frame_bit(req_address, req_command_byte,
                                   req_error_frame, 5'(j - 1))
                                ? irpdfe_pkg::SEG_ONE : irpdfe_pkg::SEG_ZERO;
      end

      if (j == NumCells - 1) begin : g_end
         assign next_kind = irpdfe_pkg::SEG_STOP;
      end else begin : g_link
         assign next_kind = kinds[j+1];
      end

      irpdfe_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_kind (load_kinds[j]),
         .next_kind (next_kind),
         .kind      (kinds[j])
      );
   end

   // ---------------- output stage ----------------
   irpdfe_seg_out u_seg_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .head_valid (cnt_ff != '0),
      .head_kind  (kinds[0]),
      .cfg        (cfg_ff),
      .out_valid  (out_valid),
      .out_mark   (rsp_mark_us),
      .out_space  (rsp_space_us),
      .out_last   (rsp_last)
   );

   assign rsp_valid = out_valid;

   // ---------------- assertions ----------------
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntFull)
      else $error("segment count beyond chain length");

   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (cnt_ff == '0) || ((cnt_ff == CntOne) && advance))
      else $error("request loaded while chain busy");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> cnt_ff == CntFull)
      else $error("chain not full after request");

   a_stop_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_space_us == '0))
      else $error("stop segment with nonzero space");

endmodule
